/* hw/rtl/flsa_pkg.sv */
// flsa_pkg: shared types and constants of the free list slot allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package flsa_pkg;

	localparam int SLOT_COUNT_DEF = 512;
	localparam int OP_W           = 2;
	localparam int IDX_W          = 9;
	localparam int STATUS_W       = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_FREED   = 3'd2,
		ST_BAD     = 3'd3,
		ST_REINIT  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_POP   = 2'd1,
		S_SWEEP = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [IDX_W-1:0] granted;
	} res_t;

endpackage
`default_nettype wire

/* hw/rtl/free_list_slot_allocator_unit.sv */
// free_list_slot_allocator_unit: LIFO free list allocator over a slot pool
// instantiates flsa_ctrl, flsa_link_mem and flsa_out_buf; uses flsa_pkg
//
// Request channel (in_valid/in_ready): op and slot_index. op allocate pops
// the head slot, op free pushes slot_index, op reinitialise rebuilds the list
// so that slot SLOT_COUNT-1 is handed out first. Each request gives exactly
// one result on the result channel (out_valid/out_ready): status and
// granted_index.
// One request is worked at a time. Free, bad index, empty and unused op
// results are formed as the request is taken and registered in the output
// buffer, and such a request can be taken every cycle while the pending
// stage is empty; a grant passes through the pop state, since the next head
// comes from a registered read of the link memory. Reinitialise rewrites
// the link memory one entry per cycle. After reset the same rebuild runs
// with in_ready low and gives no result.
// A stalled receiver is absorbed by the output register and one pending
// stage, so a further request is taken while a result waits; besides the
// pop and rebuild cycles, in_ready drops only while the pending stage is full.
`timescale 1ns / 1ps
`default_nettype none
module free_list_slot_allocator_unit #(
	parameter int SLOT_COUNT = flsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [flsa_pkg::OP_W-1:0]     op,
	input  wire logic [flsa_pkg::IDX_W-1:0]    slot_index,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [flsa_pkg::STATUS_W-1:0] status,
	output logic      [flsa_pkg::IDX_W-1:0]    granted_index
);
	import flsa_pkg::*;

	localparam int SW = $clog2(SLOT_COUNT);

	logic          wr_en;
	logic [SW-1:0] wr_addr;
	logic [SW:0]   wr_data;
	logic          rd_en;
	logic [SW-1:0] rd_addr;
	logic [SW:0]   rd_data;
	logic          buf_busy;
	res_t          res;

	flsa_ctrl #(
		.SLOT_COUNT(SLOT_COUNT),
		.SW        (SW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.slot_index(slot_index),
		.buf_busy  (buf_busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res       (res)
	);

	flsa_link_mem #(
		.SLOT_COUNT(SLOT_COUNT),
		.SW        (SW)
	) u_link_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	flsa_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.busy         (buf_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_index(granted_index)
	);

endmodule
`default_nettype wire

/* hw/rtl/flsa_link_mem.sv */
// flsa_link_mem: next-link memory, one entry per slot, valid bit on top
// one write port, one read port with registered read data; uses flsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module flsa_link_mem #(
	parameter int SLOT_COUNT = flsa_pkg::SLOT_COUNT_DEF,
	parameter int SW         = $clog2(SLOT_COUNT)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [SW-1:0] wr_addr,
	input  wire logic [SW:0]   wr_data,
	input  wire logic          rd_en,
	input  wire logic [SW-1:0] rd_addr,
	output logic      [SW:0]   rd_data
);
	import flsa_pkg::*;

	logic [SW:0] mem [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/flsa_ctrl.sv */
// flsa_ctrl: request sequencer, head register and list rebuild sweep
// drives flsa_link_mem and hands results to flsa_out_buf; uses flsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module flsa_ctrl #(
	parameter int SLOT_COUNT = flsa_pkg::SLOT_COUNT_DEF,
	parameter int SW         = $clog2(SLOT_COUNT)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [flsa_pkg::OP_W-1:0]  op,
	input  wire logic [flsa_pkg::IDX_W-1:0] slot_index,
	input  wire logic                       buf_busy,
	output logic                            wr_en,
	output logic      [SW-1:0]              wr_addr,
	output logic      [SW:0]                wr_data,
	output logic                            rd_en,
	output logic      [SW-1:0]              rd_addr,
	input  wire logic [SW:0]                rd_data,
	output flsa_pkg::res_t                  res
);
	import flsa_pkg::*;

	localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

	ctrl_state_t   state_q, state_d;
	logic [SW-1:0] head_q, head_d;
	logic          hv_q, hv_d;
	logic [SW-1:0] cnt_q, cnt_d;
	logic          reinit_q, reinit_d;
	logic          accept;
	logic          idx_ok;

	assign in_ready = (state_q == S_IDLE) && !buf_busy;
	assign accept   = in_valid && in_ready;
	assign idx_ok   = (32'(slot_index) < 32'(SLOT_COUNT));
	assign rd_addr  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_SWEEP;
			hv_q     <= 1'b0;
			cnt_q    <= '0;
			reinit_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			hv_q     <= hv_d;
			cnt_q    <= cnt_d;
			reinit_q <= reinit_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_d;
	end

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		hv_d     = hv_q;
		cnt_d    = cnt_q;
		reinit_d = reinit_q;
		wr_en    = 1'b0;
		wr_addr  = cnt_q;
		wr_data  = {(cnt_q != '0), (cnt_q == '0) ? {SW{1'b0}} : (cnt_q - 1'b1)};
		rd_en    = 1'b0;
		res      = '{valid: 1'b0, status: ST_GRANTED, granted: '0};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_ALLOC) begin
						if (hv_q) begin
							rd_en   = 1'b1;
							state_d = S_POP;
						end else begin
							res.valid  = 1'b1;
							res.status = ST_EMPTY;
						end
					end else if (op == OP_FREE) begin
						res.valid = 1'b1;
						if (idx_ok) begin
							wr_en      = 1'b1;
							wr_addr    = SW'(slot_index);
							wr_data    = {hv_q, hv_q ? head_q : {SW{1'b0}}};
							head_d     = SW'(slot_index);
							hv_d       = 1'b1;
							res.status = ST_FREED;
						end else begin
							res.status = ST_BAD;
						end
					end else if (op == OP_INIT) begin
						state_d  = S_SWEEP;
						cnt_d    = '0;
						reinit_d = 1'b1;
					end else begin
						res.valid  = 1'b1;
						res.status = ST_BAD;
					end
				end
			end
			S_POP: begin
				res.valid   = 1'b1;
				res.status  = ST_GRANTED;
				res.granted = IDX_W'(head_q);
				hv_d        = rd_data[SW];
				head_d      = rd_data[SW] ? rd_data[SW-1:0] : {SW{1'b0}};
				state_d     = S_IDLE;
			end
			S_SWEEP: begin
				wr_en = 1'b1;
				if (cnt_q == LAST) begin
					head_d   = LAST;
					hv_d     = 1'b1;
					state_d  = S_IDLE;
					reinit_d = 1'b0;
					if (reinit_q) begin
						res.valid  = 1'b1;
						res.status = ST_REINIT;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memory ports are never used in the same cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("link memory read and write in one cycle");

	// a pop read is followed by the pop cycle
	a_pop_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (state_q == S_POP))
		else $error("pop cycle missing after link read");

	// end of sweep leaves the top slot at the head
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && cnt_q == LAST) |=> (hv_q && head_q == LAST
		&& state_q == S_IDLE))
		else $error("sweep did not restore head");

endmodule
`default_nettype wire

/* hw/rtl/flsa_out_buf.sv */
// flsa_out_buf: output register plus one pending stage for results
// lets the sequencer finish a request while the receiver stalls; uses flsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module flsa_out_buf (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire flsa_pkg::res_t                res,
	output logic                               busy,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [flsa_pkg::STATUS_W-1:0] status,
	output logic      [flsa_pkg::IDX_W-1:0]    granted_index
);
	import flsa_pkg::*;

	logic    out_v_q, pend_v_q;
	status_t out_st_q, pend_st_q;
	logic [IDX_W-1:0] out_gi_q, pend_gi_q;
	logic    out_free;

	assign out_free      = !out_v_q || out_ready;
	assign busy          = pend_v_q;
	assign out_valid     = out_v_q;
	assign status        = out_st_q;
	assign granted_index = out_gi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= pend_v_q || res.valid;
			pend_v_q <= pend_v_q && res.valid;
		end else if (res.valid) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_st_q  <= pend_st_q;
				out_gi_q  <= pend_gi_q;
				pend_st_q <= res.status;
				pend_gi_q <= res.granted;
			end else if (res.valid) begin
				out_st_q <= res.status;
				out_gi_q <= res.granted;
			end
		end else if (res.valid) begin
			pend_st_q <= res.status;
			pend_gi_q <= res.granted;
		end
	end

	// a new result never meets a full pending stage
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.valid && pend_v_q))
		else $error("result arrived with pending stage full");

endmodule
`default_nettype wire

/* verif/testbench.sv */
// testbench: directed and random checks of free_list_slot_allocator_unit
// a class mirrors the free list and checks each result in order; uses flsa_pkg
`timescale 1ns / 1ps
module testbench;
	import flsa_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_AT = 1200;
	localparam int RUN_LIMIT = 400000;

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] index;
	} outcome_t;

	class free_list_mirror;
		logic [9:0] head;
		bit head_ok;
		logic [9:0] link [SLOTS];
		bit link_ok [SLOTS];
		outcome_t due [$];
		int errors;

		function new();
			errors = 0;
			rebuild();
		endfunction

		function void rebuild();
			for (int i = 0; i < SLOTS; i++) begin
				link[i] = (i == 0) ? 10'd0 : 10'(i - 1);
				link_ok[i] = (i != 0);
			end
			head = 10'(SLOTS - 1);
			head_ok = 1'b1;
		endfunction

		// returns the slot handed out, or -1
		function int take_request(logic [OP_W-1:0] code, logic [IDX_W-1:0] idx);
			outcome_t res;
			logic [9:0] top;
			int got;
			got = -1;
			res.status = ST_BAD;
			res.index = '0;
			case (code)
				OP_ALLOC: begin
					if (head_ok && head < SLOTS) begin
						top = head;
						got = int'(top);
						res.status = ST_GRANTED;
						res.index = top[IDX_W-1:0];
						head_ok = link_ok[top];
						head = link_ok[top] ? link[top] : 10'd0;
					end else begin
						res.status = ST_EMPTY;
					end
				end
				OP_FREE: begin
					if (idx < SLOTS) begin
						link[idx] = head_ok ? head : 10'd0;
						link_ok[idx] = head_ok;
						head = 10'(idx);
						head_ok = 1'b1;
						res.status = ST_FREED;
					end
				end
				OP_INIT: begin
					rebuild();
					res.status = ST_REINIT;
				end
				default: res.status = ST_BAD;
			endcase
			due.push_back(res);
			return got;
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] gi);
			outcome_t want;
			if (due.size() == 0) begin
				$display("%0t: result with no request pending, status %0d index %0d",
					$time, st, gi);
				errors++;
				return;
			end
			want = due.pop_front();
			if (st !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, st);
				errors++;
			end
			if (gi !== want.index) begin
				$display("%0t: granted_index expected %0d actual %0d", $time, want.index, gi);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [OP_W-1:0] op;
	logic [IDX_W-1:0] slot_index;
	logic out_valid;
	logic out_ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0] granted_index;

	free_list_mirror board = new();
	int held_slots [$];
	int requests_sent = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	free_list_slot_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_index(granted_index)
	);

	task automatic send_request(input logic [OP_W-1:0] code, input logic [IDX_W-1:0] idx);
		int gap;
		int got;
		int pct;
		pct = (requests_sent < 550) ? 19 : (requests_sent < 1100) ? 55 : 0;
		gap = 0;
		while ($urandom_range(99) < pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		slot_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		got = board.take_request(code, idx);
		if (got >= 0) held_slots.push_back(got);
		if (code == OP_INIT) held_slots.delete();
		requests_sent++;
	endtask

	// weights in percent; the remainder goes to the unused op code
	task automatic send_random(input int alloc_w, input int held_w, input int rand_w,
		input int init_w);
		int roll;
		int k;
		logic [IDX_W-1:0] idx;
		roll = $urandom_range(99);
		idx = IDX_W'($urandom);
		if (roll < alloc_w) begin
			send_request(OP_ALLOC, idx);
		end else if (roll < alloc_w + held_w) begin
			if (held_slots.size() == 0) begin
				send_request(OP_ALLOC, idx);
			end else begin
				k = $urandom_range(held_slots.size() - 1);
				idx = IDX_W'(held_slots[k]);
				held_slots.delete(k);
				send_request(OP_FREE, idx);
			end
		end else if (roll < alloc_w + held_w + rand_w) begin
			send_request(OP_FREE, idx);
		end else if (roll < alloc_w + held_w + rand_w + init_w) begin
			send_request(OP_INIT, idx);
		end else begin
			send_request(OP_UNUSED, idx);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		op = OP_ALLOC;
		slot_index = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_request(OP_UNUSED, '1);
		send_request(OP_UNUSED, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '1);
		send_request(OP_FREE, '1);
		// double free of a slot still on the list
		send_request(OP_FREE, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_INIT, '1);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, 9'h155);
		send_request(OP_FREE, 9'h0AA);
		send_request(OP_ALLOC, 9'h155);
		send_request(OP_ALLOC, 9'h0AA);
		send_request(OP_FREE, 9'h1FF);
		send_request(OP_ALLOC, '0);
		send_request(OP_INIT, '0);

		// drain past empty, then mixed traffic, then mostly returns
		repeat (700) send_random(92, 6, 0, 0);
		repeat (600) send_random(50, 35, 10, 2);
		repeat (330) send_random(30, 50, 12, 3);
		in_valid <= 1'b0;

		while (board.due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int stall_left;
		int pct;
		bit stall_done;
		stall_left = 0;
		stall_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) board.check_result(status, granted_index);
			pct = (requests_sent < 550) ? 55 : (requests_sent < 1100) ? 19 : 0;
			if (!stall_done && requests_sent >= STALL_AT) begin
				stall_done = 1'b1;
				stall_left = 150;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= pct);
			end
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
